>>> sv/cau_pkg.sv
// Shared types, operation codes and default widths for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_ADD = 2'd0;
  localparam mode_t MODE_SUB = 2'd1;
  localparam mode_t MODE_MUL = 2'd2;
  localparam mode_t MODE_DIV = 2'd3;

  // control riding along the front pipeline
  typedef struct packed {
    logic  valid;
    mode_t mode;
  } ctl_t;

  // flags riding along the divider stages
  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic dir_clip;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } side_t;

endpackage

>>> sv/cau_div_stage.sv
// One restoring-division step: resolves one quotient bit, registered.
module cau_div_stage import cau_pkg::*; #(
  parameter int DW   = DATA_WIDTH_DEF,
  parameter int MW   = 3 * DATA_WIDTH_DEF + 1,
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic [MW-1:0]     rem_i,
  input  logic [DW-1:0]     q_i,
  input  logic [2*DW-1:0]   dvs_i,
  output logic [MW-1:0]     rem_o,
  output logic [DW-1:0]     q_o
);

  logic [MW-1:0] cmp;
  logic          ge;
  logic [MW-1:0] rem_nxt;
  logic [DW-1:0] q_nxt;

  always_comb begin
    cmp     = MW'(dvs_i) << STEP;
    ge      = (rem_i >= cmp);
    rem_nxt = ge ? (rem_i - cmp) : rem_i;
    q_nxt   = q_i;
    q_nxt[STEP] = ge;
  end

  always_ff @(posedge clk) begin
    rem_o <= rem_nxt;
    q_o   <= q_nxt;
  end

endmodule

>>> sv/cau_front.sv
// Front pipeline: input register, products, sums, and divide/direct preparation.
module cau_front import cau_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int NW = 2 * DATA_WIDTH_DEF + 1 + FRAC_BITS_DEF,
  parameter int MW = 3 * DATA_WIDTH_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  mode_t                in_mode,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  output side_t                side_o,
  output logic [DW-1:0]        dir_re_o,
  output logic [DW-1:0]        dir_im_o,
  output logic [NW-1:0]        mag_re_o,
  output logic [NW-1:0]        mag_im_o,
  output logic [2*DW-1:0]      dvs_o
);

  localparam int SW = 2 * DW + 1;

  // stage 1: operands
  ctl_t                 c1_r;
  logic signed [DW-1:0] ar_r, ai_r, br_r, bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else begin
      c1_r <= '{valid: in_take, mode: in_mode};
    end
  end

  always_ff @(posedge clk) begin
    ar_r <= in_a_re;
    ai_r <= in_a_im;
    br_r <= in_b_re;
    bi_r <= in_b_im;
  end

  // stage 2: products and add/sub
  ctl_t                   c2_r;
  logic signed [2*DW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_bbr_r, p_bbi_r;
  logic signed [DW:0]     as_re_r, as_im_r;
  logic signed [DW:0]     as_re_nxt, as_im_nxt;

  always_comb begin
    if (c1_r.mode == MODE_SUB) begin
      as_re_nxt = {ar_r[DW-1], ar_r} - {br_r[DW-1], br_r};
      as_im_nxt = {ai_r[DW-1], ai_r} - {bi_r[DW-1], bi_r};
    end else begin
      as_re_nxt = {ar_r[DW-1], ar_r} + {br_r[DW-1], br_r};
      as_im_nxt = {ai_r[DW-1], ai_r} + {bi_r[DW-1], bi_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
    end else begin
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_rr_r  <= ar_r * br_r;
    p_ii_r  <= ai_r * bi_r;
    p_ir_r  <= ai_r * br_r;
    p_ri_r  <= ar_r * bi_r;
    p_bbr_r <= br_r * br_r;
    p_bbi_r <= bi_r * bi_r;
    as_re_r <= as_re_nxt;
    as_im_r <= as_im_nxt;
  end

  // stage 3: sums of products
  ctl_t                 c3_r;
  logic signed [SW-1:0] mre_r, mim_r, nre_r, nim_r;
  logic [2*DW-1:0]      d_r;
  logic signed [DW:0]   as_re3_r, as_im3_r;
  logic signed [SW-1:0] e_rr, e_ii, e_ir, e_ri;

  assign e_rr = {p_rr_r[2*DW-1], p_rr_r};
  assign e_ii = {p_ii_r[2*DW-1], p_ii_r};
  assign e_ir = {p_ir_r[2*DW-1], p_ir_r};
  assign e_ri = {p_ri_r[2*DW-1], p_ri_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r <= '0;
    end else begin
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    mre_r    <= e_rr - e_ii;
    mim_r    <= e_ir + e_ri;
    nre_r    <= e_rr + e_ii;
    nim_r    <= e_ir - e_ri;
    d_r      <= $unsigned(p_bbr_r) + $unsigned(p_bbi_r);
    as_re3_r <= as_re_r;
    as_im3_r <= as_im_r;
  end

  // stage 4: direct result saturation, divide magnitudes and overflow
  logic signed [SW-1:0] dv_re, dv_im;
  logic                 cl_re, cl_im;
  logic [DW-1:0]        sv_re, sv_im;
  logic signed [NW-1:0] num_re, num_im;
  logic [NW-1:0]        mg_re, mg_im;
  logic [MW-1:0]        lim;
  side_t                side_nxt;

  always_comb begin
    if (c3_r.mode == MODE_MUL) begin
      dv_re = mre_r >>> FB;
      dv_im = mim_r >>> FB;
    end else begin
      dv_re = SW'(as_re3_r);
      dv_im = SW'(as_im3_r);
    end
    cl_re = !((&dv_re[SW-1:DW-1]) || !(|dv_re[SW-1:DW-1]));
    cl_im = !((&dv_im[SW-1:DW-1]) || !(|dv_im[SW-1:DW-1]));
    sv_re = cl_re ? {dv_re[SW-1], {(DW-1){~dv_re[SW-1]}}} : dv_re[DW-1:0];
    sv_im = cl_im ? {dv_im[SW-1], {(DW-1){~dv_im[SW-1]}}} : dv_im[DW-1:0];

    num_re = NW'(nre_r) <<< FB;
    num_im = NW'(nim_r) <<< FB;
    mg_re  = num_re[NW-1] ? NW'(-num_re) : NW'(num_re);
    mg_im  = num_im[NW-1] ? NW'(-num_im) : NW'(num_im);
    lim    = MW'(d_r) << DW;

    side_nxt.valid    = c3_r.valid;
    side_nxt.is_div   = (c3_r.mode == MODE_DIV);
    side_nxt.dz       = (d_r == '0);
    side_nxt.dir_clip = cl_re || cl_im;
    side_nxt.neg_re   = num_re[NW-1];
    side_nxt.neg_im   = num_im[NW-1];
    side_nxt.ovf_re   = (MW'(mg_re) >= lim);
    side_nxt.ovf_im   = (MW'(mg_im) >= lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o <= '0;
    end else begin
      side_o <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_re_o <= sv_re;
    dir_im_o <= sv_im;
    mag_re_o <= mg_re;
    mag_im_o <= mg_im;
    dvs_o    <= d_r;
  end

endmodule

>>> sv/complex_arith_unit.sv
// Top level of the complex arithmetic unit: front pipeline, divider stages, output stage.
//
// Usage:
//   An item (mode, a, b) is taken at a rising edge with start high and busy low.
//   busy is always low: the datapath is fully pipelined, one item per cycle.
//   mode: add, subtract, multiply (Q-format product, floor shift by FRAC_BITS)
//   or divide (a * conj(b) / |b|^2, quotient truncated toward zero).
//   Each item gives exactly one result, shown for one cycle with out_valid high.
//   The path holds DATA_WIDTH + 5 register stages. It is the same for every
//   mode, so results leave in order. The depth is set by the divider: one
//   quotient bit per stage, DATA_WIDTH stages, after four front stages
//   (operands, products, sums, magnitude/overflow prep) and one output register.
//   Quotients at or above 2^DATA_WIDTH are caught before the divider and
//   saturate; out_saturated marks any clipped part.
//   A divide by zero gives zero parts with out_div_zero high.
//   Reset (rst_n low, synchronous) clears all valid bits; items in flight
//   are dropped. The receiver cannot stall: results must be taken as shown.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_saturated,
  output logic                         out_div_zero
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = 2 * DW + 1 + FRAC_BITS;            // signed numerator << FRAC_BITS
  localparam int MW = ((NW > 3 * DW) ? NW : 3 * DW) + 1; // remainder width

  assign busy = 1'b0;

  // front pipeline
  side_t           side0;
  logic [DW-1:0]   dir_re0, dir_im0;
  logic [NW-1:0]   mag_re0, mag_im0;
  logic [2*DW-1:0] dvs0;

  cau_front #(.DW(DW), .FB(FRAC_BITS), .NW(NW), .MW(MW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (start && !busy),
    .in_mode  (in_mode),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .side_o   (side0),
    .dir_re_o (dir_re0),
    .dir_im_o (dir_im0),
    .mag_re_o (mag_re0),
    .mag_im_o (mag_im0),
    .dvs_o    (dvs0)
  );

  // divider pipeline; stage k resolves quotient bit DW-1-k for both parts
  side_t           side_r  [DW+1];
  logic [DW-1:0]   dre_r   [DW+1];
  logic [DW-1:0]   dim_r   [DW+1];
  logic [2*DW-1:0] dvs_r   [DW+1];
  logic [MW-1:0]   rre     [DW+1];
  logic [MW-1:0]   rim     [DW+1];
  logic [DW-1:0]   qre     [DW+1];
  logic [DW-1:0]   qim     [DW+1];

  assign side_r[0] = side0;
  assign dre_r[0]  = dir_re0;
  assign dim_r[0]  = dir_im0;
  assign dvs_r[0]  = dvs0;
  assign rre[0]    = MW'(mag_re0);
  assign rim[0]    = MW'(mag_im0);
  assign qre[0]    = '0;
  assign qim[0]    = '0;

  for (genvar k = 0; k < DW; k++) begin : g_div
    cau_div_stage #(.DW(DW), .MW(MW), .STEP(DW - 1 - k)) u_re (
      .clk   (clk),
      .rem_i (rre[k]),
      .q_i   (qre[k]),
      .dvs_i (dvs_r[k]),
      .rem_o (rre[k+1]),
      .q_o   (qre[k+1])
    );
    cau_div_stage #(.DW(DW), .MW(MW), .STEP(DW - 1 - k)) u_im (
      .clk   (clk),
      .rem_i (rim[k]),
      .q_i   (qim[k]),
      .dvs_i (dvs_r[k]),
      .rem_o (rim[k+1]),
      .q_o   (qim[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k+1] <= '0;
      end else begin
        side_r[k+1] <= side_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dre_r[k+1] <= dre_r[k];
      dim_r[k+1] <= dim_r[k];
      dvs_r[k+1] <= dvs_r[k];
    end
  end

  // output stage: sign and saturate quotients, give zero on a divide by zero, or pass direct results
  side_t         sf;
  logic [DW-1:0] qf_re, qf_im;
  logic [DW-1:0] half;
  logic          qc_re, qc_im;
  logic [DW-1:0] qv_re, qv_im;
  logic          valid_nxt, sat_nxt, dz_nxt;
  logic [DW-1:0] re_nxt, im_nxt;

  assign sf    = side_r[DW];
  assign qf_re = qre[DW];
  assign qf_im = qim[DW];
  assign half  = {1'b1, {(DW-1){1'b0}}};

  always_comb begin
    // positive clips above max; negative clips beyond magnitude of min
    qc_re = sf.ovf_re || (sf.neg_re ? (qf_re > half) : qf_re[DW-1]);
    qc_im = sf.ovf_im || (sf.neg_im ? (qf_im > half) : qf_im[DW-1]);
    if (qc_re) begin
      qv_re = sf.neg_re ? half : ~half;
    end else begin
      qv_re = sf.neg_re ? (~qf_re + 1'b1) : qf_re;
    end
    if (qc_im) begin
      qv_im = sf.neg_im ? half : ~half;
    end else begin
      qv_im = sf.neg_im ? (~qf_im + 1'b1) : qf_im;
    end

    valid_nxt = sf.valid;
    dz_nxt    = 1'b0;
    if (!sf.is_div) begin
      re_nxt  = dre_r[DW];
      im_nxt  = dim_r[DW];
      sat_nxt = sf.dir_clip;
    end else if (sf.dz) begin
      re_nxt  = '0;
      im_nxt  = '0;
      sat_nxt = 1'b0;
      dz_nxt  = 1'b1;
    end else begin
      re_nxt  = qv_re;
      im_nxt  = qv_im;
      sat_nxt = qc_re || qc_im;
    end
    if (!sf.valid) begin
      sat_nxt = 1'b0;
      dz_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid     <= 1'b0;
      out_saturated <= 1'b0;
      out_div_zero  <= 1'b0;
    end else begin
      out_valid     <= valid_nxt;
      out_saturated <= sat_nxt;
      out_div_zero  <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_re <= re_nxt;
    out_res_im <= im_nxt;
  end

  // checks
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_div_zero |-> (out_res_re == '0 && out_res_im == '0 && !out_saturated))
    else $error("divide-by-zero result not zero");

  a_flags_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_div_zero || out_saturated) |-> out_valid)
    else $error("flag raised without a result");

  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    side_r[DW].valid |=> out_valid)
    else $error("item lost in output stage");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the complex arithmetic unit.
`timescale 1ns / 1ps

module testbench;
  import cau_pkg::*;

  localparam int DW      = DATA_WIDTH_DEF;
  localparam int FB      = FRAC_BITS_DEF;
  localparam int LATENCY = DW + 5;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 sat;
    logic                 dz;
  } cplx_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic signed [DW-1:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic out_valid;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic out_saturated, out_div_zero;

  cplx_result_t expected_q[$];
  int  error_count;
  longint cycle_count;
  int  send_idle_pct;

  complex_arith_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_a_re, .in_a_im, .in_b_re, .in_b_im,
    .out_valid, .out_res_re, .out_res_im, .out_saturated, .out_div_zero
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Clip to the signed data range, note whether clipping happened.
  function automatic longint clip_part(longint v, ref logic hit);
    longint hi, lo;
    hi = (longint'(1) << (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Expected result of one operation; >>> on longint is a floor shift,
  // longint division truncates toward zero.
  function automatic cplx_result_t compute_cplx(mode_t op, logic signed [DW-1:0] ar,
      logic signed [DW-1:0] ai, logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
    longint rr, ri, d;
    logic hit;
    cplx_result_t r;
    rr = 0; ri = 0; hit = 1'b0;
    r.dz = 1'b0;
    case (op)
      MODE_ADD: begin
        rr = longint'(ar) + longint'(br);
        ri = longint'(ai) + longint'(bi);
      end
      MODE_SUB: begin
        rr = longint'(ar) - longint'(br);
        ri = longint'(ai) - longint'(bi);
      end
      MODE_MUL: begin
        rr = (longint'(ar) * br - longint'(ai) * bi) >>> FB;
        ri = (longint'(ai) * br + longint'(ar) * bi) >>> FB;
      end
      default: begin
        d = longint'(br) * br + longint'(bi) * bi;
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          rr = ((longint'(ar) * br + longint'(ai) * bi) * (longint'(1) << FB)) / d;
          ri = ((longint'(ai) * br - longint'(ar) * bi) * (longint'(1) << FB)) / d;
        end
      end
    endcase
    rr = clip_part(rr, hit);
    ri = clip_part(ri, hit);
    r.re  = rr[DW-1:0];
    r.im  = ri[DW-1:0];
    r.sat = hit;
    return r;
  endfunction

  // Drive one item and hold until the accepting edge; random gaps before it.
  task automatic send_item(mode_t op, logic [DW-1:0] ar, logic [DW-1:0] ai,
      logic [DW-1:0] br, logic [DW-1:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_mode <= op;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(compute_cplx(op, ar, ai, br, bi));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Operand biased toward extremes, zero and small values.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(9))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return '0;
      3, 4: return DW'($signed($urandom_range(2048)) - 1024);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [DW-1:0] mx, mn, one;
    mx  = {1'b0, {(DW-1){1'b1}}};
    mn  = {1'b1, {(DW-1){1'b0}}};
    one = DW'(1 << FB);
    send_item(MODE_ADD, mx, mx, mx, mx);           // positive overflow
    send_item(MODE_ADD, mn, mn, mn, mn);           // negative overflow
    send_item(MODE_ADD, 16'h0123, 16'hFF00, 16'h0001, 16'h0100);
    send_item(MODE_SUB, mn, mx, mx, mn);
    send_item(MODE_SUB, mx, mn, mn, mx);
    send_item(MODE_SUB, 16'h1234, 16'h5678, 16'h1234, 16'h5678);
    send_item(MODE_MUL, mn, mn, mn, mn);
    send_item(MODE_MUL, mx, mx, mx, mn);
    send_item(MODE_MUL, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000); // floor of -1/256
    send_item(MODE_MUL, one, 16'h0080, one, 16'hFF80);
    send_item(MODE_DIV, one, one, 16'h0000, 16'h0000);           // zero divisor
    send_item(MODE_DIV, mx, mn, 16'h0000, 16'h0000);
    send_item(MODE_DIV, mx, mx, 16'h0001, 16'h0000);             // huge quotient
    send_item(MODE_DIV, mn, mn, 16'h0000, 16'hFFFF);
    send_item(MODE_DIV, 16'hFFFF, 16'h0001, 16'h0003, 16'h0000); // truncate toward zero
    send_item(MODE_DIV, one, 16'h0000, one, one);
    send_item(MODE_DIV, mn, mx, mn, mx);
    send_item(MODE_DIV, 16'h0000, 16'h0000, mn, mn);
    drain_results();
  endtask

  task automatic test_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      send_item(mode_t'($urandom_range(3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
    end
    send_idle_pct = 0;
  endtask

  // Every result is checked against the oldest expectation.
  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result re=%0d im=%0d", out_res_re, out_res_im);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_res_re !== exp_r.re) begin
          $error("res_re: expected %0d, got %0d", exp_r.re, out_res_re);
          error_count++;
        end
        if (out_res_im !== exp_r.im) begin
          $error("res_im: expected %0d, got %0d", exp_r.im, out_res_im);
          error_count++;
        end
        if (out_saturated !== exp_r.sat) begin
          $error("saturated: expected %0b, got %0b", exp_r.sat, out_saturated);
          error_count++;
        end
        if (out_div_zero !== exp_r.dz) begin
          $error("div_zero: expected %0b, got %0b", exp_r.dz, out_div_zero);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_mode = MODE_ADD;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(550, 28);
    drain_results();             // sender holds off until all results are back
    test_random(550, 63);
    test_random(550, 0);
    drain_results();

    repeat (LATENCY + 5) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cau_pkg.sv
sv/cau_div_stage.sv
sv/cau_front.sv
sv/complex_arith_unit.sv
tb/sv/testbench.sv
